// ----- rtl/tnft_pkg.sv -----
`timescale 1ns / 1ps
package tnft_pkg;

  localparam int TableDepth = 64;
  localparam int PortPool   = 256;
  localparam int RuleSlots  = 4;
  localparam int QueueDepth = 2;

  localparam logic [2:0] StFwd    = 3'd0;
  localparam logic [2:0] StNoPort = 3'd1;
  localparam logic [2:0] StNoMap  = 3'd2;
  localparam logic [2:0] StFull   = 3'd3;
  localparam logic [2:0] StTick   = 3'd4;

  localparam logic [2:0] RegExtIp   = 3'd0;
  localparam logic [2:0] RegPortBase = 3'd1;
  localparam logic [2:0] RegIdle    = 3'd2;
  localparam logic [2:0] RegRuleCnt = 3'd3;
  localparam logic [2:0] RegRule0   = 3'd4;

  localparam logic [2:0] KindTick = 3'd0;
  localparam logic [2:0] KindOut  = 3'd1;
  localparam logic [2:0] KindIn   = 3'd2;
  localparam logic [2:0] KindDrop = 3'd3;

  typedef struct packed {
    logic        cmd;
    logic        dir;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic        fin;
    logic [31:0] ack_num;
    logic [31:0] seq_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_ip;
    logic [15:0] new_port;
    logic [6:0]  removed_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [63:0] data;
  } cfg_req_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic        rule_hit;
    logic [31:0] rule_ip;
    logic [15:0] rule_port;
    in_item_t    pkt;
  } job_t;

endpackage

// ----- rtl/tnft_ram.sv -----
`timescale 1ns / 1ps
module tnft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/tnft_front.sv -----
`timescale 1ns / 1ps
module tnft_front #(
  parameter int RuleSlots = tnft_pkg::RuleSlots
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tnft_pkg::in_item_t   in_data,
  input  logic [31:0]          wan_ip,
  input  logic [2:0]           rule_count,
  input  logic [63:0]          rules [RuleSlots],
  output logic                 q_valid,
  input  logic                 q_stall,
  output tnft_pkg::job_t       q_data
);
  tnft_pkg::job_t job;
  logic [2:0] n_rules;
  logic       hit;
  logic [31:0] hip;
  logic [15:0] hport;

  // rule match over a handful of registers, first match wins
  always_comb begin
    n_rules = (rule_count > 3'(RuleSlots)) ? 3'(RuleSlots) : rule_count;
    hit = 1'b0;
    hip = '0;
    hport = '0;
    for (int i = RuleSlots - 1; i >= 0; i--) begin
      if (3'(i) < n_rules && rules[i][15:0] == in_data.dst_port) begin
        hit = 1'b1;
        hip = rules[i][63:32];
        hport = rules[i][31:16];
      end
    end
    job.pkt = in_data;
    job.rule_hit = hit;
    job.rule_ip = hip;
    job.rule_port = hport;
    if (in_data.cmd) job.kind = tnft_pkg::KindTick;
    else if (!in_data.dir) job.kind = tnft_pkg::KindOut;
    else if (in_data.dst_ip != wan_ip) job.kind = tnft_pkg::KindDrop;
    else job.kind = tnft_pkg::KindIn;
  end

  tnft_pkg::job_t buf_q [tnft_pkg::QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] cnt;

  assign in_stall = (cnt == 2'(tnft_pkg::QueueDepth));
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        buf_q[wr_ptr] <= job;
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && !q_stall) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(in_valid && !in_stall) - 2'(q_valid && !q_stall);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'(tnft_pkg::QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !(q_valid)) else $error("valid on empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_stall) |=> q_valid) else $error("queue lost request");
endmodule

// ----- rtl/tnft_back.sv -----
`timescale 1ns / 1ps
module tnft_back #(
  parameter int TableDepth = tnft_pkg::TableDepth,
  parameter int PortPool   = tnft_pkg::PortPool
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  tnft_pkg::job_t       q_data,
  input  logic [31:0]          wan_ip,
  input  logic [15:0]          port_base,
  input  logic [15:0]          idle_timeout,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tnft_pkg::out_item_t  out_data
);
  localparam int EW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int PW = (PortPool > 1) ? $clog2(PortPool) : 1;
  // key: remote ip, remote port, internal ip, internal port, external port
  localparam int KW = 112;
  // track: fin_i, fin_x, ack_i, ack_x, send_i, send_x, last_seen, pooled, pool idx
  localparam int TW = 2 + 32 * 5 + 1 + PW;
  // top bit set marks "nothing found"
  localparam logic [EW:0] NoEntry = {1'b1, {EW{1'b0}}};
  localparam logic [PW:0] NoPort  = {1'b1, {PW{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_PSCAN, S_PSCAN_W, S_WRITE, S_TSCAN, S_TSCAN_W, S_OUT
  } state_t;

  state_t state;
  tnft_pkg::job_t job;
  logic [EW:0] idx;
  logic [PW:0] pidx;
  logic [EW:0] hit_e, free_e;
  logic [PW:0] free_p;
  logic        is_new;
  logic [31:0] now_s;
  logic [6:0]  removed;
  logic [TableDepth-1:0] valid_bits;
  logic [PortPool-1:0]   port_used;

  logic          k_we, t_we;
  logic [EW-1:0] k_waddr, t_waddr, raddr;
  logic [KW-1:0] k_wdata, k_rdata;
  logic [TW-1:0] t_wdata, t_rdata;

  tnft_ram #(.Width(KW), .Depth(TableDepth)) u_key (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr, .rdata(k_rdata));
  tnft_ram #(.Width(TW), .Depth(TableDepth)) u_trk (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr, .rdata(t_rdata));

  logic [31:0] r_rip, r_iip;
  logic [15:0] r_rport, r_iport, r_xport;
  logic        r_fi, r_fx, r_pooled;
  logic [31:0] r_ai, r_ax, r_si, r_sx, r_last;
  logic [PW-1:0] r_pidx;
  assign {r_rip, r_rport, r_iip, r_iport, r_xport} = k_rdata;
  assign {r_fi, r_fx, r_ai, r_ax, r_si, r_sx, r_last, r_pooled, r_pidx} = t_rdata;

  logic [EW-1:0] cur;
  logic cur_valid, key_match, expire;
  logic [31:0] age;
  assign cur = idx[EW-1:0] - EW'(1);
  assign raddr = idx[EW-1:0];
  assign cur_valid = valid_bits[cur];
  assign age = now_s - r_last;
  assign expire = (r_fi && r_fx && r_ai >= r_sx && r_ax >= r_si) ||
                  (age >= {16'd0, idle_timeout});
  always_comb begin
    if (job.kind == tnft_pkg::KindOut)
      key_match = r_rip == job.pkt.dst_ip && r_rport == job.pkt.dst_port &&
                  r_iip == job.pkt.src_ip && r_iport == job.pkt.src_port;
    else
      key_match = r_rip == job.pkt.src_ip && r_rport == job.pkt.src_port &&
                  r_xport == job.pkt.dst_port;
  end

  logic [15:0] pool_port;
  assign pool_port = port_base + 16'(free_p);

  assign q_stall = (state != S_IDLE);

  // write ports: scan entry update on S_WRITE
  always_comb begin
    k_we = 1'b0; t_we = 1'b0;
    k_waddr = hit_e[EW-1:0]; t_waddr = hit_e[EW-1:0];
    k_wdata = '0; t_wdata = '0;
    if (state == S_WRITE) begin
      if (is_new) begin
        k_we = 1'b1;
        k_waddr = free_e[EW-1:0];
        t_waddr = free_e[EW-1:0];
        if (job.kind == tnft_pkg::KindOut)
          k_wdata = {job.pkt.dst_ip, job.pkt.dst_port, job.pkt.src_ip, job.pkt.src_port,
                     pool_port};
        else
          k_wdata = {job.pkt.src_ip, job.pkt.src_port, job.rule_ip, job.rule_port,
                     job.pkt.dst_port};
      end
      t_we = 1'b1;
      if (job.kind == tnft_pkg::KindOut)
        t_wdata = {job.pkt.fin, (is_new ? 1'b0 : r_fx), job.pkt.ack_num,
                   (is_new ? 32'd0 : r_ax), job.pkt.seq_end, (is_new ? 32'd0 : r_sx),
                   now_s, (is_new ? 1'b1 : r_pooled),
                   (is_new ? free_p[PW-1:0] : r_pidx)};
      else
        t_wdata = {(is_new ? 1'b0 : r_fi), job.pkt.fin, (is_new ? 32'd0 : r_ai),
                   job.pkt.ack_num, (is_new ? 32'd0 : r_si), job.pkt.seq_end,
                   now_s, (is_new ? 1'b0 : r_pooled), (is_new ? PW'(0) : r_pidx)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      valid_bits <= '0;
      port_used <= '0;
      now_s <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_data;
            idx <= '0;
            pidx <= '0;
            hit_e <= NoEntry;
            free_e <= NoEntry;
            free_p <= NoPort;
            removed <= '0;
            if (q_data.kind == tnft_pkg::KindTick) begin
              now_s <= now_s + 32'd1;
              state <= S_TSCAN;
            end else if (q_data.kind == tnft_pkg::KindDrop) begin
              out_data <= '{tnft_pkg::StNoMap, 32'd0, 16'd0, 7'd0};
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        // issue read of entry idx, compare on following cycle
        S_SCAN: begin
          idx <= idx + (EW+1)'(1);
          state <= S_SCAN_W;
        end
        S_SCAN_W: begin
          if (cur_valid && key_match && hit_e[EW]) hit_e <= {1'b0, cur};
          if (!cur_valid && free_e[EW]) free_e <= {1'b0, cur};
          if (idx == (EW+1)'(TableDepth)) begin
            state <= S_PSCAN;
          end else begin
            idx <= idx + (EW+1)'(1);
          end
        end
        S_PSCAN: begin
          if (!hit_e[EW]) begin
            idx <= hit_e;
            state <= S_PSCAN_W;
          end else if (job.kind == tnft_pkg::KindOut) begin
            if (pidx == (PW+1)'(PortPool) || !free_p[PW]) begin
              if (free_p[PW]) begin
                out_data <= '{tnft_pkg::StNoPort, 32'd0, 16'd0, 7'd0};
                out_valid <= 1'b1; state <= S_OUT;
              end else if (free_e[EW]) begin
                out_data <= '{tnft_pkg::StFull, 32'd0, 16'd0, 7'd0};
                out_valid <= 1'b1; state <= S_OUT;
              end else begin
                is_new <= 1'b1; state <= S_WRITE;
              end
            end else begin
              if (!port_used[pidx[PW-1:0]]) free_p <= pidx;
              pidx <= pidx + (PW+1)'(1);
            end
          end else begin
            if (!job.rule_hit) begin
              out_data <= '{tnft_pkg::StNoMap, 32'd0, 16'd0, 7'd0};
              out_valid <= 1'b1; state <= S_OUT;
            end else if (free_e[EW]) begin
              out_data <= '{tnft_pkg::StFull, 32'd0, 16'd0, 7'd0};
              out_valid <= 1'b1; state <= S_OUT;
            end else begin
              is_new <= 1'b1; state <= S_WRITE;
            end
          end
        end
        // re-read the hit entry so its other side's fields are kept
        S_PSCAN_W: begin
          is_new <= 1'b0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (is_new) begin
            valid_bits[free_e[EW-1:0]] <= 1'b1;
            if (job.kind == tnft_pkg::KindOut) port_used[free_p[PW-1:0]] <= 1'b1;
          end
          out_valid <= 1'b1;
          if (job.kind == tnft_pkg::KindOut)
            out_data <= '{tnft_pkg::StFwd, wan_ip,
                          (is_new ? pool_port : r_xport), 7'd0};
          else
            out_data <= '{tnft_pkg::StFwd, (is_new ? job.rule_ip : r_iip),
                          (is_new ? job.rule_port : r_iport), 7'd0};
          state <= S_OUT;
        end
        S_TSCAN: begin
          idx <= idx + (EW+1)'(1);
          state <= S_TSCAN_W;
        end
        S_TSCAN_W: begin
          if (cur_valid && expire) begin
            valid_bits[cur] <= 1'b0;
            if (r_pooled) port_used[r_pidx] <= 1'b0;
            if (removed != 7'd127) removed <= removed + 7'd1;
          end
          if (idx == (EW+1)'(TableDepth)) begin
            out_data <= '{tnft_pkg::StTick, 32'd0, 16'd0,
                          (cur_valid && expire && removed != 7'd127) ? removed + 7'd1
                                                                      : removed};
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            idx <= idx + (EW+1)'(1);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_stall) |=> $stable(out_data)) else $error("result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && is_new) |-> !valid_bits[free_e[EW-1:0]])
    else $error("insert over live entry");
endmodule

// ----- rtl/tcp_nat_flow_table.sv -----
`timescale 1ns / 1ps
// A matched packet scans the table, re-reads its entry and writes it back; a new inbound flow
// is written to a free entry, a new outbound flow after a port pool search; a tick scans the
// table. Dropped inbound to another address: answered from idle. One request is in work at a
// time; the next starts once a result is taken. A two-entry queue sits ahead of the engine.
// Reset (rst, synchronous) clears all flows, pool ports, the second counter and registers
// to their defaults; no clearing pass is needed.
module tcp_nat_flow_table #(
  parameter int TableDepth = tnft_pkg::TableDepth,
  parameter int PortPool   = tnft_pkg::PortPool,
  parameter int RuleSlots  = tnft_pkg::RuleSlots
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tnft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tnft_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tnft_pkg::cfg_req_t  cfg_data
);
  logic [31:0] wan_ip;
  logic [15:0] port_base, idle_timeout;
  logic [2:0]  rule_count;
  logic [63:0] rules [RuleSlots];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wan_ip <= '0;
      port_base <= 16'd1024;
      idle_timeout <= 16'd60;
      rule_count <= '0;
      for (int i = 0; i < RuleSlots; i++) rules[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_data.index)
        tnft_pkg::RegExtIp:    wan_ip <= cfg_data.data[31:0];
        tnft_pkg::RegPortBase: port_base <= cfg_data.data[15:0];
        tnft_pkg::RegIdle:     idle_timeout <= cfg_data.data[15:0];
        tnft_pkg::RegRuleCnt:  rule_count <= cfg_data.data[2:0];
        default: begin
          for (int i = 0; i < RuleSlots; i++)
            if (cfg_data.index == tnft_pkg::RegRule0 + 3'(i)) rules[i] <= cfg_data.data;
        end
      endcase
    end
  end

  logic           q_valid, q_stall;
  tnft_pkg::job_t q_data;

  tnft_front #(.RuleSlots(RuleSlots)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .wan_ip, .rule_count, .rules,
    .q_valid, .q_stall, .q_data);

  tnft_back #(.TableDepth(TableDepth), .PortPool(PortPool)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data, .wan_ip, .port_base, .idle_timeout,
    .out_valid, .out_stall, .out_data);
endmodule
